>>> hdl/dfma_pkg.sv
// ----------------------------------------------------------------------------
// Double FMA package
// Shared types, constants and helper functions for the binary64 fused
// multiply-add unit.
// ----------------------------------------------------------------------------
package dfma_pkg;

   // Depth of the queue between the front end and the arithmetic back end.
   localparam int DFMA_QUEUE_DEPTH = 4;

   // Rounding mode codes.
   localparam logic [1:0] RM_NEAREST_EVEN = 2'd0;
   localparam logic [1:0] RM_TOWARD_ZERO  = 2'd1;
   localparam logic [1:0] RM_UPWARD       = 2'd2;
   localparam logic [1:0] RM_DOWNWARD     = 2'd3;

   // Binary64 bit patterns.
   localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;
   localparam logic [63:0] SIGN_BIT    = 64'h8000_0000_0000_0000;
   localparam logic [63:0] DEFAULT_NAN = 64'h7FF8_0000_0000_0000;
   localparam logic [63:0] INF_BITS    = 64'h7FF0_0000_0000_0000;
   localparam logic [63:0] MAX_FINITE  = 64'h7FEF_FFFF_FFFF_FFFF;

   // Signed exponent wide enough for every intermediate exponent.
   typedef logic signed [12:0] exp_type;

   // Fields that ride along with a request through the whole back end.
   typedef struct packed {
      logic        special;
      logic [63:0] special_result;
      logic [1:0]  rm;
   } dfma_tag_type;

   // One classified request as it sits in the queue.
   typedef struct packed {
      dfma_tag_type tag;
      logic         ps;
      logic         sc;
      logic         c_zero;
      logic [52:0]  ma;
      logic [52:0]  mb;
      logic [52:0]  mc;
      exp_type      ea;
      exp_type      eb;
      exp_type      ec;
      logic [5:0]   lza;
      logic [5:0]   lzb;
      logic [5:0]   lzc;
   } dfma_item_type;

   // Leading zero count of a 64-bit word by binary halving (63 for zero).
   function automatic logic [5:0] lzc64(input logic [63:0] v);
      logic [63:0] t;
      logic [5:0]  n;
      t = v;
      n = '0;
      if (t[63:32] == 32'd0) begin
         n[5] = 1'b1;
         t    = {t[31:0], 32'd0};
      end
      if (t[63:48] == 16'd0) begin
         n[4] = 1'b1;
         t    = {t[47:0], 16'd0};
      end
      if (t[63:56] == 8'd0) begin
         n[3] = 1'b1;
         t    = {t[55:0], 8'd0};
      end
      if (t[63:60] == 4'd0) begin
         n[2] = 1'b1;
         t    = {t[59:0], 4'd0};
      end
      if (t[63:62] == 2'd0) begin
         n[1] = 1'b1;
         t    = {t[61:0], 2'd0};
      end
      if (!t[63]) begin
         n[0] = 1'b1;
      end
      return n;
   endfunction

endpackage

>>> hdl/dfma_if.sv
// ----------------------------------------------------------------------------
// Double FMA channel interfaces
// Valid/ready channels for requests, responses and the rounding mode register.
// ----------------------------------------------------------------------------

// Request channel: three binary64 operands.
interface dfma_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] operand_a;
   logic [63:0] operand_b;
   logic [63:0] operand_c;

   modport source (output valid, output operand_a, output operand_b, output operand_c,
                   input ready);
   modport sink   (input valid, input operand_a, input operand_b, input operand_c,
                   output ready);
endinterface

// Response channel: the rounded result.
interface dfma_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] fused_result;

   modport source (output valid, output fused_result, input ready);
   modport sink   (input valid, input fused_result, output ready);
endinterface

// Register write channel: the rounding mode.
interface dfma_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] rounding_mode;

   modport source (output valid, output rounding_mode, input ready);
   modport sink   (input valid, input rounding_mode, output ready);
endinterface

>>> hdl/dfma_front.sv
// ----------------------------------------------------------------------------
// Double FMA front end
// Holds the rounding mode, accepts requests, resolves NaN, infinity and zero
// cases and unpacks the operands for the back end.
// ----------------------------------------------------------------------------
module dfma_front
   import dfma_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   dfma_req_if.sink      req_ch,
   dfma_csr_if.sink      csr_ch,
   output dfma_item_type item,
   output logic          item_valid,
   input  logic          item_ready
);

   logic [1:0] rm_ff;
   logic [1:0] rm_in;

   logic [63:0] a, b, c;
   logic        sa, sb, sc, ps;
   logic        nan_a, nan_b, nan_c, inf_a, inf_b, inf_c;
   logic        zero_a, zero_b, zero_c;
   logic        special;
   logic [63:0] special_result;

   // Rounding mode register; writes are always taken.
   assign csr_ch.ready = 1'b1;
   assign rm_in        = (csr_ch.valid) ? csr_ch.rounding_mode : rm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rm_ff <= RM_NEAREST_EVEN;
      end else begin
         rm_ff <= rm_in;
      end
   end

   assign a = req_ch.operand_a;
   assign b = req_ch.operand_b;
   assign c = req_ch.operand_c;

   // Operand classification.
   always_comb begin
      sa     = a[63];
      sb     = b[63];
      sc     = c[63];
      ps     = sa ^ sb;
      nan_a  = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
      nan_b  = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
      nan_c  = (c[62:52] == 11'h7FF) && (c[51:0] != 52'd0);
      inf_a  = (a[62:52] == 11'h7FF) && (a[51:0] == 52'd0);
      inf_b  = (b[62:52] == 11'h7FF) && (b[51:0] == 52'd0);
      inf_c  = (c[62:52] == 11'h7FF) && (c[51:0] == 52'd0);
      zero_a = (a[62:0] == 63'd0);
      zero_b = (b[62:0] == 63'd0);
      zero_c = (c[62:0] == 63'd0);
   end

   // Results that need no arithmetic, in priority order.
   always_comb begin
      special        = 1'b1;
      special_result = '0;
      if (nan_a) begin
         special_result = a | QUIET_BIT;
      end else if (nan_b) begin
         special_result = b | QUIET_BIT;
      end else if (nan_c) begin
         special_result = c | QUIET_BIT;
      end else if (inf_a || inf_b) begin
         if (zero_a || zero_b) begin
            special_result = DEFAULT_NAN;
         end else if (inf_c && (sc != ps)) begin
            special_result = DEFAULT_NAN;
         end else begin
            special_result = {ps, INF_BITS[62:0]};
         end
      end else if (inf_c) begin
         special_result = c;
      end else if (zero_a || zero_b) begin
         if (!zero_c) begin
            special_result = c;
         end else if (ps == sc) begin
            special_result = {sc, 63'd0};
         end else begin
            special_result = (rm_ff == RM_DOWNWARD) ? SIGN_BIT : 64'd0;
         end
      end else begin
         special = 1'b0;
      end
   end

   // Unpacked significands, exponents of their lowest bits and shift counts
   // that bring a subnormal significand up to the hidden bit position.
   always_comb begin
      item.tag.special        = special;
      item.tag.special_result = special_result;
      item.tag.rm             = rm_ff;
      item.ps                 = ps;
      item.sc                 = sc;
      item.c_zero             = zero_c;
      item.ma  = {(a[62:52] != 11'd0), a[51:0]};
      item.mb  = {(b[62:52] != 11'd0), b[51:0]};
      item.mc  = {(c[62:52] != 11'd0), c[51:0]};
      item.ea  = (a[62:52] == 11'd0) ? -13'sd1074 : $signed({2'b00, a[62:52]}) - 13'sd1075;
      item.eb  = (b[62:52] == 11'd0) ? -13'sd1074 : $signed({2'b00, b[62:52]}) - 13'sd1075;
      item.ec  = (c[62:52] == 11'd0) ? -13'sd1074 : $signed({2'b00, c[62:52]}) - 13'sd1075;
      item.lza = lzc64({item.ma, 11'd0});
      item.lzb = lzc64({item.mb, 11'd0});
      item.lzc = lzc64({item.mc, 11'd0});
   end

   assign item_valid   = req_ch.valid;
   assign req_ch.ready = item_ready;

endmodule

>>> hdl/dfma_queue.sv
// ----------------------------------------------------------------------------
// Double FMA queue
// Small first-in first-out buffer of classified requests between the front
// end and the back end.
// ----------------------------------------------------------------------------
module dfma_queue
   import dfma_pkg::*;
#(
   parameter int DEPTH = DFMA_QUEUE_DEPTH
)(
   input  logic          clock,
   input  logic          reset,
   input  dfma_item_type in_item,
   input  logic          in_valid,
   output logic          in_ready,
   output dfma_item_type out_item,
   output logic          out_valid,
   input  logic          out_ready
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST  = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL  = CW'(DEPTH);

   dfma_item_type entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          push, pop;

   assign in_ready  = (count_ff != FULL);
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_item  = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

>>> hdl/dfma_back.sv
// ----------------------------------------------------------------------------
// Double FMA back end
// Ten-stage pipeline: significand normalize, partial products, product sum,
// alignment select, alignment shift, add, leading zero count, normalize,
// subnormal shift and rounding into the response register.
// ----------------------------------------------------------------------------
module dfma_back
   import dfma_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  dfma_item_type item,
   input  logic          item_valid,
   output logic          item_ready,
   dfma_rsp_if.source    rsp_ch
);

   logic         adv;
   logic [10:1]  vld_ff, vld_in;
   dfma_tag_type tag_ff [1:9];

   // Stage 1: normalized significands.
   logic [52:0] s1_ma_ff, s1_ma_in, s1_mb_ff, s1_mb_in, s1_mc_ff, s1_mc_in;
   exp_type     s1_ea_ff, s1_ea_in, s1_eb_ff, s1_eb_in, s1_ec_ff, s1_ec_in;
   logic        s1_ps_ff, s1_sc_ff, s1_cz_ff;
   // Stage 2: partial products.
   logic [53:0] s2_hh_ff, s2_hh_in;
   logic [52:0] s2_hl_ff, s2_hl_in, s2_lh_ff, s2_lh_in;
   logic [51:0] s2_ll_ff, s2_ll_in;
   exp_type     s2_esum_ff, s2_esum_in, s2_ec_ff;
   logic [52:0] s2_mc_ff;
   logic        s2_ps_ff, s2_sc_ff, s2_cz_ff;
   // Stage 3: full product.
   logic [105:0] s3_prod_ff, s3_prod_in;
   exp_type      s3_esum_ff, s3_ec_ff;
   logic [52:0]  s3_mc_ff;
   logic         s3_ps_ff, s3_sc_ff, s3_cz_ff;
   // Stage 4: larger and smaller term.
   logic [127:0] s4_x_ff, s4_x_in, s4_y_ff, s4_y_in;
   exp_type      s4_d_ff, s4_d_in, s4_e_ff, s4_e_in;
   logic         s4_sx_ff, s4_sx_in, s4_sy_ff, s4_sy_in;
   // Stage 5: aligned smaller term.
   logic [127:0] s5_x_ff, s5_y_ff, s5_y_in;
   exp_type      s5_e_ff;
   logic         s5_sx_ff, s5_sy_ff;
   // Stage 6: magnitude of the sum.
   logic [127:0] s6_m_ff, s6_m_in;
   exp_type      s6_e_ff;
   logic         s6_rs_ff, s6_rs_in;
   // Stage 7: half-word leading zero counts.
   logic [127:0] s7_m_ff;
   logic [5:0]   s7_lzh_ff, s7_lzh_in, s7_lzl_ff, s7_lzl_in;
   logic         s7_hz_ff, s7_hz_in, s7_zero_ff, s7_zero_in, s7_rs_ff;
   exp_type      s7_e_ff;
   // Stage 8: normalized magnitude.
   logic [127:0] s8_n_ff, s8_n_in;
   exp_type      s8_be_ff, s8_be_in;
   logic [6:0]   s8_lz;
   logic         s8_zero_ff, s8_rs_ff;
   // Stage 9: mantissa, round and sticky bits.
   logic [52:0]  s9_mant_ff, s9_mant_in;
   logic         s9_rb_ff, s9_rb_in, s9_sb_ff, s9_sb_in;
   exp_type      s9_be_ff;
   logic         s9_zero_ff, s9_rs_ff;
   // Stage 10: response register.
   logic [63:0]  s10_res_ff, s10_res_in;

   // The whole pipeline moves unless the response register is held.
   assign adv        = !vld_ff[10] || rsp_ch.ready;
   assign item_ready = adv;
   assign vld_in     = {vld_ff[9:1], item_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // Stage 1: bring subnormal significands up to the hidden bit.
   always_comb begin
      s1_ma_in = item.ma << item.lza;
      s1_mb_in = item.mb << item.lzb;
      s1_mc_in = item.mc << item.lzc;
      s1_ea_in = item.ea - $signed({7'd0, item.lza});
      s1_eb_in = item.eb - $signed({7'd0, item.lzb});
      s1_ec_in = item.ec - $signed({7'd0, item.lzc});
   end

   // Stage 2: four partial products of the split significands.
   always_comb begin
      s2_hh_in   = 54'(s1_ma_ff[52:26]) * 54'(s1_mb_ff[52:26]);
      s2_hl_in   = 53'(s1_ma_ff[52:26]) * 53'(s1_mb_ff[25:0]);
      s2_lh_in   = 53'(s1_ma_ff[25:0]) * 53'(s1_mb_ff[52:26]);
      s2_ll_in   = 52'(s1_ma_ff[25:0]) * 52'(s1_mb_ff[25:0]);
      s2_esum_in = s1_ea_ff + s1_eb_ff;
   end

   // Stage 3: sum of the partial products.
   assign s3_prod_in = {s2_hh_ff, 52'd0} + {27'd0, s2_hl_ff, 26'd0}
                     + {27'd0, s2_lh_ff, 26'd0} + {54'd0, s2_ll_ff};

   // Stage 4: place both terms with their top bit at 125, pick the larger.
   always_comb begin
      logic [127:0] mp, mcw, wide;
      exp_type      lp, lc;
      logic         swap;
      wide  = {22'd0, s3_prod_ff};
      mp    = s3_prod_ff[105] ? (wide << 20) : (wide << 21);
      mcw   = {2'b00, s3_mc_ff, 73'd0};
      lp    = s3_esum_ff + (s3_prod_ff[105] ? 13'sd105 : 13'sd104);
      lc    = s3_ec_ff + 13'sd52;
      swap  = !s3_cz_ff && (lp < lc);
      s4_x_in  = swap ? mcw : mp;
      s4_y_in  = swap ? mp : mcw;
      s4_sx_in = swap ? s3_sc_ff : s3_ps_ff;
      s4_sy_in = swap ? s3_ps_ff : s3_sc_ff;
      s4_d_in  = swap ? (lc - lp) : (lp - lc);
      s4_e_in  = (swap ? lc : lp) - 13'sd125;
   end

   // Stage 5: right shift of the smaller term, lost bits jammed into bit 0.
   always_comb begin
      logic         big, jam;
      logic [127:0] mask;
      big     = (s4_d_ff[12:7] != 6'd0);
      mask    = (128'd1 << s4_d_ff[6:0]) - 128'd1;
      jam     = big ? (|s4_y_ff) : (|(s4_y_ff & mask));
      s5_y_in = (big ? 128'd0 : (s4_y_ff >> s4_d_ff[6:0])) | {127'd0, jam};
   end

   // Stage 6: signed magnitude add.
   always_comb begin
      logic [128:0] diff;
      diff = {1'b0, s5_x_ff} - {1'b0, s5_y_ff};
      if (s5_sx_ff == s5_sy_ff) begin
         s6_m_in  = s5_x_ff + s5_y_ff;
         s6_rs_in = s5_sx_ff;
      end else if (!diff[128]) begin
         s6_m_in  = diff[127:0];
         s6_rs_in = s5_sx_ff;
      end else begin
         s6_m_in  = s5_y_ff - s5_x_ff;
         s6_rs_in = s5_sy_ff;
      end
   end

   // Stage 7: leading zeros of each half.
   always_comb begin
      s7_lzh_in  = lzc64(s6_m_ff[127:64]);
      s7_lzl_in  = lzc64(s6_m_ff[63:0]);
      s7_hz_in   = (s6_m_ff[127:64] == 64'd0);
      s7_zero_in = (s6_m_ff == 128'd0);
   end

   // Stage 8: normalize to bit 127 and form the biased exponent.
   always_comb begin
      s8_lz    = s7_hz_ff ? ({1'b0, s7_lzl_ff} + 7'd64) : {1'b0, s7_lzh_ff};
      s8_n_in  = s7_m_ff << s8_lz;
      s8_be_in = s7_e_ff + 13'sd1150 - $signed({6'd0, s8_lz});
   end

   // Stage 9: extra right shift for subnormal results, then split off the
   // mantissa, the round bit and the sticky bit.
   always_comb begin
      exp_type      k;
      logic         big, jam;
      logic [127:0] mask, sh;
      k    = (s8_be_ff < 13'sd1) ? (13'sd1 - s8_be_ff) : 13'sd0;
      big  = (k[12:7] != 6'd0);
      mask = (128'd1 << k[6:0]) - 128'd1;
      jam  = big ? (|s8_n_ff) : (|(s8_n_ff & mask));
      sh   = big ? 128'd0 : (s8_n_ff >> k[6:0]);
      s9_mant_in = sh[127:75];
      s9_rb_in   = sh[74];
      s9_sb_in   = (|sh[73:0]) | jam;
   end

   // Stage 10: rounding, overflow and final selection.
   always_comb begin
      logic        up, to_inf, ovf;
      logic [53:0] mant;
      logic [63:0] bits, ovf_val;
      exp_type     be_m1;
      case (tag_ff[9].rm)
         RM_NEAREST_EVEN: up = s9_rb_ff && (s9_sb_ff || s9_mant_ff[0]);
         RM_UPWARD:       up = (s9_rb_ff || s9_sb_ff) && !s9_rs_ff;
         RM_DOWNWARD:     up = (s9_rb_ff || s9_sb_ff) && s9_rs_ff;
         default:         up = 1'b0;
      endcase
      to_inf = (tag_ff[9].rm == RM_NEAREST_EVEN)
            || ((tag_ff[9].rm == RM_UPWARD) && !s9_rs_ff)
            || ((tag_ff[9].rm == RM_DOWNWARD) && s9_rs_ff);
      ovf_val = {s9_rs_ff, to_inf ? INF_BITS[62:0] : MAX_FINITE[62:0]};
      mant    = {1'b0, s9_mant_ff} + {53'd0, up};
      be_m1   = s9_be_ff - 13'sd1;
      bits    = (s9_be_ff >= 13'sd1) ? ({be_m1[10:0], 53'd0} >> 1) + {10'd0, mant}
                                     : {10'd0, mant};
      ovf     = (s9_be_ff > 13'sd2046) || (bits >= INF_BITS);
      if (tag_ff[9].special) begin
         s10_res_in = tag_ff[9].special_result;
      end else if (s9_zero_ff) begin
         s10_res_in = (tag_ff[9].rm == RM_DOWNWARD) ? SIGN_BIT : 64'd0;
      end else if (ovf) begin
         s10_res_in = ovf_val;
      end else begin
         s10_res_in = {s9_rs_ff, bits[62:0]};
      end
   end

   // Pipeline payload registers.
   always_ff @(posedge clock) begin
      if (adv) begin
         tag_ff[1] <= item.tag;
         for (int i = 2; i <= 9; i++) begin
            tag_ff[i] <= tag_ff[i-1];
         end
         s1_ma_ff <= s1_ma_in;
         s1_mb_ff <= s1_mb_in;
         s1_mc_ff <= s1_mc_in;
         s1_ea_ff <= s1_ea_in;
         s1_eb_ff <= s1_eb_in;
         s1_ec_ff <= s1_ec_in;
         s1_ps_ff <= item.ps;
         s1_sc_ff <= item.sc;
         s1_cz_ff <= item.c_zero;

         s2_hh_ff   <= s2_hh_in;
         s2_hl_ff   <= s2_hl_in;
         s2_lh_ff   <= s2_lh_in;
         s2_ll_ff   <= s2_ll_in;
         s2_esum_ff <= s2_esum_in;
         s2_ec_ff   <= s1_ec_ff;
         s2_mc_ff   <= s1_mc_ff;
         s2_ps_ff   <= s1_ps_ff;
         s2_sc_ff   <= s1_sc_ff;
         s2_cz_ff   <= s1_cz_ff;

         s3_prod_ff <= s3_prod_in;
         s3_esum_ff <= s2_esum_ff;
         s3_ec_ff   <= s2_ec_ff;
         s3_mc_ff   <= s2_mc_ff;
         s3_ps_ff   <= s2_ps_ff;
         s3_sc_ff   <= s2_sc_ff;
         s3_cz_ff   <= s2_cz_ff;

         s4_x_ff  <= s4_x_in;
         s4_y_ff  <= s4_y_in;
         s4_d_ff  <= s4_d_in;
         s4_e_ff  <= s4_e_in;
         s4_sx_ff <= s4_sx_in;
         s4_sy_ff <= s4_sy_in;

         s5_x_ff  <= s4_x_ff;
         s5_y_ff  <= s5_y_in;
         s5_e_ff  <= s4_e_ff;
         s5_sx_ff <= s4_sx_ff;
         s5_sy_ff <= s4_sy_ff;

         s6_m_ff  <= s6_m_in;
         s6_e_ff  <= s5_e_ff;
         s6_rs_ff <= s6_rs_in;

         s7_m_ff    <= s6_m_ff;
         s7_lzh_ff  <= s7_lzh_in;
         s7_lzl_ff  <= s7_lzl_in;
         s7_hz_ff   <= s7_hz_in;
         s7_zero_ff <= s7_zero_in;
         s7_rs_ff   <= s6_rs_ff;
         s7_e_ff    <= s6_e_ff;

         s8_n_ff    <= s8_n_in;
         s8_be_ff   <= s8_be_in;
         s8_zero_ff <= s7_zero_ff;
         s8_rs_ff   <= s7_rs_ff;

         s9_mant_ff <= s9_mant_in;
         s9_rb_ff   <= s9_rb_in;
         s9_sb_ff   <= s9_sb_in;
         s9_be_ff   <= s8_be_ff;
         s9_zero_ff <= s8_zero_ff;
         s9_rs_ff   <= s8_rs_ff;

         s10_res_ff <= s10_res_in;
      end
   end

   assign rsp_ch.valid        = vld_ff[10];
   assign rsp_ch.fused_result = s10_res_ff;

endmodule

>>> hdl/double_fused_multiply_add_unit.sv
// ----------------------------------------------------------------------------
// Double fused multiply-add unit
// Computes a*b+c on IEEE 754 binary64 operands with a single rounding.
// ----------------------------------------------------------------------------
// The unit takes one request per cycle while the queue has room and returns one
// result per request, in order. A request is classified in the cycle it is
// accepted and written into a small queue; the arithmetic pipeline then adds
// ten stages. Throughput is one request per cycle while nothing stalls: the
// ten-stage back end advances as a whole whenever its response register is
// empty or being taken. The rounding mode is written through the register
// channel; the user must write it only while the unit is idle, which the block
// itself does not enforce. It applies to every later request; NaN, infinity and
// zero operands give the IEEE 754 special results and travel through the same pipeline.
module double_fused_multiply_add_unit
   import dfma_pkg::*;
#(
   parameter int QUEUE_DEPTH = DFMA_QUEUE_DEPTH
)(
   input  logic       clock,
   input  logic       reset,
   dfma_req_if.sink   req_ch,
   dfma_rsp_if.source rsp_ch,
   dfma_csr_if.sink   csr_ch
);

   dfma_item_type front_item, back_item;
   logic          front_valid, front_ready;
   logic          back_valid, back_ready;

   // Request classification and the rounding mode register.
   dfma_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .csr_ch     (csr_ch),
      .item       (front_item),
      .item_valid (front_valid),
      .item_ready (front_ready)
   );

   // Decoupling queue.
   dfma_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_item   (front_item),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .out_item  (back_item),
      .out_valid (back_valid),
      .out_ready (back_ready)
   );

   // Arithmetic pipeline and response register.
   dfma_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (back_item),
      .item_valid (back_valid),
      .item_ready (back_ready),
      .rsp_ch     (rsp_ch)
   );

endmodule
